// ===== design/rhw_pkg.sv =====
package rhw_pkg;

  localparam int unsigned COORD_W   = 4;
  localparam int unsigned GRID_SIDE = 16;
  localparam int unsigned IDX_W     = 2 * COORD_W;

  localparam int unsigned DEF_MAZE_ROWS    = 16;
  localparam int unsigned DEF_MAZE_COLUMNS = 16;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [1:0] DIR_EAST  = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_WEST  = 2'd2;
  localparam logic [1:0] DIR_NORTH = 2'd3;

  localparam logic [1:0] TRY_RIGHT   = 2'd0;
  localparam logic [1:0] TRY_FORWARD = 2'd1;
  localparam logic [1:0] TRY_LEFT    = 2'd2;
  localparam logic [1:0] TRY_BACK    = 2'd3;

  function automatic logic [1:0] turn_dir(logic [1:0] facing, logic [1:0] attempt);
    logic [1:0] dir;
    case (attempt)
      TRY_RIGHT:   dir = facing + 2'd1;
      TRY_FORWARD: dir = facing;
      TRY_LEFT:    dir = facing + 2'd3;
      TRY_BACK:    dir = facing + 2'd2;
      default:     dir = facing;
    endcase
    return dir;
  endfunction

  function automatic logic edge_blocked(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                        logic [1:0] dir, logic [COORD_W-1:0] last_r,
                                        logic [COORD_W-1:0] last_c);
    logic hit;
    case (dir)
      DIR_EAST:  hit = (c == last_c);
      DIR_SOUTH: hit = (r == last_r);
      DIR_WEST:  hit = (c == '0);
      DIR_NORTH: hit = (r == '0);
      default:   hit = 1'b1;
    endcase
    return hit;
  endfunction

  function automatic logic [COORD_W-1:0] nbr_row(logic [COORD_W-1:0] r, logic [1:0] dir);
    logic [COORD_W-1:0] n;
    case (dir)
      DIR_SOUTH: n = r + COORD_W'(1);
      DIR_NORTH: n = r - COORD_W'(1);
      default:   n = r;
    endcase
    return n;
  endfunction

  function automatic logic [COORD_W-1:0] nbr_col(logic [COORD_W-1:0] c, logic [1:0] dir);
    logic [COORD_W-1:0] n;
    case (dir)
      DIR_EAST: n = c + COORD_W'(1);
      DIR_WEST: n = c - COORD_W'(1);
      default:  n = c;
    endcase
    return n;
  endfunction

endpackage

// ===== design/rhw_ram.sv =====
module rhw_ram #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/right_hand_maze_walker.sv =====
// Right-hand-rule maze walker over a grid of up to 16 by 16 cells. The wall bits and the
// visited bits live in two memories, each with a separate write port and a registered read.
// A start item clears the visited memory one cell per cycle before the next item is
// accepted; after reset a pass clears both memories in the same way. A step item probes
// the sides in the order right, forward, left, back, each one a wall-memory read, until
// one is open or all are tried, and waits while the output register is still full.
// A step after the walk has ended reads no memory. Only one item is in flight at a time;
// the result sits in an output register until its transfer.
module right_hand_maze_walker #(
  parameter int unsigned MAZE_ROWS    = rhw_pkg::DEF_MAZE_ROWS,
  parameter int unsigned MAZE_COLUMNS = rhw_pkg::DEF_MAZE_COLUMNS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [3:0] row_i,
  input  logic [3:0] column_i,
  input  logic       wall_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] cur_row_o,
  output logic [3:0] cur_column_o,
  output logic [1:0] heading_o,
  output logic       revisited_o,
  output logic       finished_o,
  output logic       stuck_o
);

  localparam int unsigned CW = rhw_pkg::COORD_W;
  localparam int unsigned IW = rhw_pkg::IDX_W;
  localparam int unsigned EffRows =
      (MAZE_ROWS < rhw_pkg::GRID_SIDE) ? MAZE_ROWS : rhw_pkg::GRID_SIDE;
  localparam int unsigned EffColumns =
      (MAZE_COLUMNS < rhw_pkg::GRID_SIDE) ? MAZE_COLUMNS : rhw_pkg::GRID_SIDE;
  localparam logic [CW-1:0] LastRow = CW'(EffRows - 1);
  localparam logic [CW-1:0] LastCol = CW'(EffColumns - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEval  = 2'd1;
  localparam logic [1:0] StClear = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_wall_q, clr_wall_d;
  logic [CW-1:0] pos_row_q, pos_row_d;
  logic [CW-1:0] pos_col_q, pos_col_d;
  logic [1:0]    facing_q, facing_d;
  logic          moved_q, moved_d;
  logic          done_q, done_d;
  logic          out_valid_q, out_valid_d;

  logic [CW-1:0] out_row_q, out_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [1:0]    out_head_q, out_head_d;
  logic          out_rev_q, out_rev_d;
  logic          out_fin_q, out_fin_d;
  logic          out_stuck_q, out_stuck_d;

  logic [1:0]    try_q, try_d;
  logic [1:0]    dir_q, dir_d;
  logic          oob_q, oob_d;
  logic          rev_q, rev_d;
  logic          first_q, first_d;
  logic          done_step_q, done_step_d;

  logic          wall_we, wall_wdata, wall_re, wall_rdata;
  logic [IW-1:0] wall_waddr, wall_raddr;
  logic          vis_we, vis_wdata, vis_re, vis_rdata;
  logic [IW-1:0] vis_waddr, vis_raddr;

  logic          in_fire, slot_free, on_border, finish, open_side, rev;
  logic [1:0]    probe_try, probe_dir;
  logic          probe_oob;
  logic [IW-1:0] pos_idx;

  rhw_ram #(.AW(IW), .DW(1)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (wall_waddr),
    .wdata_i (wall_wdata),
    .re_i    (wall_re),
    .raddr_i (wall_raddr),
    .rdata_o (wall_rdata)
  );

  rhw_ram #(.AW(IW), .DW(1)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign pos_idx    = {pos_row_q, pos_col_q};
  assign on_border  = (pos_row_q == '0) || (pos_col_q == '0) ||
                      (pos_row_q == LastRow) || (pos_col_q == LastCol);
  assign finish     = moved_q && on_border;
  assign open_side  = !oob_q && !wall_rdata;
  assign rev        = first_q ? vis_rdata : rev_q;

  assign probe_try  = (state_q == StIdle) ? rhw_pkg::TRY_RIGHT : (try_q + 2'd1);
  assign probe_dir  = rhw_pkg::turn_dir(facing_q, probe_try);
  assign probe_oob  = rhw_pkg::edge_blocked(pos_row_q, pos_col_q, probe_dir, LastRow, LastCol);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_wall_d  = clr_wall_q;
    pos_row_d   = pos_row_q;
    pos_col_d   = pos_col_q;
    facing_d    = facing_q;
    moved_d     = moved_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_head_d  = out_head_q;
    out_rev_d   = out_rev_q;
    out_fin_d   = out_fin_q;
    out_stuck_d = out_stuck_q;
    try_d       = try_q;
    dir_d       = dir_q;
    oob_d       = oob_q;
    rev_d       = rev_q;
    first_d     = first_q;
    done_step_d = done_step_q;

    wall_we    = 1'b0;
    wall_waddr = {row_i, column_i};
    wall_wdata = wall_i;
    wall_re    = 1'b0;
    wall_raddr = {rhw_pkg::nbr_row(pos_row_q, probe_dir),
                  rhw_pkg::nbr_col(pos_col_q, probe_dir)};
    vis_we     = 1'b0;
    vis_waddr  = pos_idx;
    vis_wdata  = 1'b1;
    vis_re     = 1'b0;
    vis_raddr  = pos_idx;

    case (state_q)
      StClear: begin
        wall_we    = clr_wall_q;
        wall_waddr = clr_cnt_q;
        wall_wdata = 1'b0;
        vis_we     = 1'b1;
        vis_waddr  = clr_cnt_q;
        vis_wdata  = 1'b0;
        clr_cnt_d  = clr_cnt_q + IW'(1);
        if (clr_cnt_q == '1) begin
          clr_wall_d = 1'b0;
          state_d    = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          case (kind_i)
            rhw_pkg::KIND_WRITE: begin
              wall_we = (row_i <= LastRow) && (column_i <= LastCol);
            end
            rhw_pkg::KIND_START: begin
              pos_row_d = (row_i > LastRow) ? LastRow : row_i;
              pos_col_d = (column_i > LastCol) ? LastCol : column_i;
              facing_d  = rhw_pkg::DIR_EAST;
              moved_d   = 1'b0;
              done_d    = 1'b0;
              clr_cnt_d = '0;
              state_d   = StClear;
            end
            rhw_pkg::KIND_STEP: begin
              done_step_d = done_q;
              first_d     = 1'b1;
              try_d       = rhw_pkg::TRY_RIGHT;
              dir_d       = probe_dir;
              oob_d       = probe_oob;
              wall_re     = !done_q;
              vis_re      = !done_q;
              state_d     = StEval;
            end
            default: begin
            end
          endcase
        end
      end
      StEval: begin
        if (done_step_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_row_d   = pos_row_q;
            out_col_d   = pos_col_q;
            out_head_d  = facing_q;
            out_rev_d   = 1'b1;
            out_fin_d   = finish;
            out_stuck_d = !finish;
            state_d     = StIdle;
          end
        end else begin
          vis_we  = 1'b1;
          rev_d   = rev;
          first_d = 1'b0;
          if (finish || open_side || (try_q == rhw_pkg::TRY_BACK)) begin
            if (slot_free) begin
              out_valid_d = 1'b1;
              out_rev_d   = rev;
              out_fin_d   = finish;
              out_stuck_d = 1'b0;
              out_row_d   = pos_row_q;
              out_col_d   = pos_col_q;
              out_head_d  = facing_q;
              state_d     = StIdle;
              if (finish) begin
                done_d = 1'b1;
              end else if (open_side) begin
                pos_row_d  = rhw_pkg::nbr_row(pos_row_q, dir_q);
                pos_col_d  = rhw_pkg::nbr_col(pos_col_q, dir_q);
                facing_d   = dir_q;
                moved_d    = 1'b1;
                out_row_d  = rhw_pkg::nbr_row(pos_row_q, dir_q);
                out_col_d  = rhw_pkg::nbr_col(pos_col_q, dir_q);
                out_head_d = dir_q;
              end else begin
                out_stuck_d = 1'b1;
                done_d      = 1'b1;
              end
            end
          end else begin
            try_d   = probe_try;
            dir_d   = probe_dir;
            oob_d   = probe_oob;
            wall_re = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      clr_wall_q  <= 1'b1;
      pos_row_q   <= '0;
      pos_col_q   <= '0;
      facing_q    <= rhw_pkg::DIR_EAST;
      moved_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_wall_q  <= clr_wall_d;
      pos_row_q   <= pos_row_d;
      pos_col_q   <= pos_col_d;
      facing_q    <= facing_d;
      moved_q     <= moved_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_head_q  <= out_head_d;
    out_rev_q   <= out_rev_d;
    out_fin_q   <= out_fin_d;
    out_stuck_q <= out_stuck_d;
    try_q       <= try_d;
    dir_q       <= dir_d;
    oob_q       <= oob_d;
    rev_q       <= rev_d;
    first_q     <= first_d;
    done_step_q <= done_step_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cur_row_o    = out_row_q;
  assign cur_column_o = out_col_q;
  assign heading_o    = out_head_q;
  assign revisited_o  = out_rev_q;
  assign finished_o   = out_fin_q;
  assign stuck_o      = out_stuck_q;

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(finished_o && stuck_o))
    else $error("result reports finished and stuck together");

  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_row_o <= LastRow) && (cur_column_o <= LastCol))
    else $error("walker position left the grid");

  a_no_wall_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEval) |-> !wall_we)
    else $error("wall memory written while a step is evaluated");

  a_step_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEval) && (state_d == StIdle) |=> out_valid_q)
    else $error("step finished without a result");

endmodule

// ===== dv/right_hand_maze_walker_test.sv =====
module right_hand_maze_walker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ROWS = (rhw_pkg::DEF_MAZE_ROWS < rhw_pkg::GRID_SIDE) ?
                        rhw_pkg::DEF_MAZE_ROWS : rhw_pkg::GRID_SIDE;
  localparam int COLS = (rhw_pkg::DEF_MAZE_COLUMNS < rhw_pkg::GRID_SIDE) ?
                        rhw_pkg::DEF_MAZE_COLUMNS : rhw_pkg::GRID_SIDE;
  localparam int WALK_ITEMS = 950;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int QUIET_ITEMS = 150;
  localparam logic [1:0] TURN_OFFSET [4] = '{2'd1, 2'd0, 2'd3, 2'd2};

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] row;
    logic [3:0] column;
    logic       wall;
  } maze_item_t;

  typedef struct packed {
    logic [3:0] cur_row;
    logic [3:0] cur_column;
    logic [1:0] heading;
    logic       revisited;
    logic       finished;
    logic       stuck;
  } walk_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i = rhw_pkg::KIND_WRITE;
  logic [3:0] row_i = '0;
  logic [3:0] column_i = '0;
  logic       wall_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] cur_row_o;
  logic [3:0] cur_column_o;
  logic [1:0] heading_o;
  logic       revisited_o;
  logic       finished_o;
  logic       stuck_o;

  right_hand_maze_walker dut (.*);

  always #4 clk_i = ~clk_i;

  maze_item_t   pending_items[$];
  walk_result_t expected_walk[$];
  maze_item_t   next_item;
  walk_result_t got_walk;
  walk_result_t want_walk;
  walk_result_t new_walk;

  bit [255:0] wall_bits;
  bit [255:0] visited_bits;
  logic [3:0] at_row;
  logic [3:0] at_col;
  logic [1:0] heading_now;
  bit         has_moved;
  bit         walk_over;

  bit quiet_tail = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int items_total = 0;
  int walk_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int finished_seen = 0;
  int stuck_seen = 0;
  int revisit_seen = 0;
  int failures = 0;

  function automatic int row_step(logic [1:0] dir);
    case (dir)
      rhw_pkg::DIR_SOUTH: return 1;
      rhw_pkg::DIR_NORTH: return -1;
      default:            return 0;
    endcase
  endfunction

  function automatic int col_step(logic [1:0] dir);
    case (dir)
      rhw_pkg::DIR_EAST: return 1;
      rhw_pkg::DIR_WEST: return -1;
      default:           return 0;
    endcase
  endfunction

  function automatic bit cell_blocked(int r, int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 1'b1;
    return wall_bits[r * rhw_pkg::GRID_SIDE + c];
  endfunction

  function automatic bit at_border();
    return at_row == 0 || at_col == 0 || at_row == 4'(ROWS - 1) || at_col == 4'(COLS - 1);
  endfunction

  function automatic bit predict_walk(input maze_item_t it, output walk_result_t res);
    int unsigned k;
    logic [1:0] dir;
    int nr;
    int nc;
    bit went;
    res = '0;
    case (it.kind)
      rhw_pkg::KIND_WRITE: begin
        if (it.row < ROWS && it.column < COLS) wall_bits[{it.row, it.column}] = it.wall;
        return 1'b0;
      end
      rhw_pkg::KIND_START: begin
        at_row = (it.row < ROWS) ? it.row : 4'(ROWS - 1);
        at_col = (it.column < COLS) ? it.column : 4'(COLS - 1);
        heading_now = rhw_pkg::DIR_EAST;
        visited_bits = '0;
        has_moved = 1'b0;
        walk_over = 1'b0;
        return 1'b0;
      end
      rhw_pkg::KIND_STEP: ;
      default: return 1'b0;
    endcase
    if (walk_over) begin
      res.revisited = 1'b1;
      res.finished = has_moved && at_border();
      res.stuck = !res.finished;
    end else begin
      res.revisited = visited_bits[{at_row, at_col}];
      visited_bits[{at_row, at_col}] = 1'b1;
      if (has_moved && at_border()) begin
        res.finished = 1'b1;
        walk_over = 1'b1;
      end else begin
        went = 1'b0;
        for (k = 0; k < 4 && !went; k++) begin
          dir = heading_now + TURN_OFFSET[k];
          nr = int'(at_row) + row_step(dir);
          nc = int'(at_col) + col_step(dir);
          if (!cell_blocked(nr, nc)) begin
            heading_now = dir;
            at_row = nr[3:0];
            at_col = nc[3:0];
            has_moved = 1'b1;
            went = 1'b1;
          end
        end
        if (!went) begin
          res.stuck = 1'b1;
          walk_over = 1'b1;
        end
      end
    end
    res.cur_row = at_row;
    res.cur_column = at_col;
    res.heading = heading_now;
    return 1'b1;
  endfunction

  task automatic add_item(logic [1:0] kind, logic [3:0] row, logic [3:0] column, logic wall);
    pending_items.push_back('{kind: kind, row: row, column: column, wall: wall});
    items_total++;
    if (kind != KIND_UNUSED) walk_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i <= rhw_pkg::KIND_WRITE;
      row_i <= '0;
      column_i <= '0;
      wall_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= next_item.kind;
        row_i <= next_item.row;
        column_i <= next_item.column;
        wall_i <= next_item.wall;
        if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
      quiet_tail <= pending_items.size() < QUIET_ITEMS;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 11);
      end
      out_ready_i <= (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_walk = '{cur_row: cur_row_o, cur_column: cur_column_o, heading: heading_o,
                     revisited: revisited_o, finished: finished_o, stuck: stuck_o};
        if (expected_walk.size() == 0) begin
          $error("Result transfer with no step pending: row %0d column %0d",
                 cur_row_o, cur_column_o);
          failures++;
        end else begin
          want_walk = expected_walk.pop_front();
          results_checked++;
          if (got_walk.cur_row !== want_walk.cur_row) begin
            $error("cur_row expected %0d got %0d", want_walk.cur_row, got_walk.cur_row);
            failures++;
          end
          if (got_walk.cur_column !== want_walk.cur_column) begin
            $error("cur_column expected %0d got %0d", want_walk.cur_column,
                   got_walk.cur_column);
            failures++;
          end
          if (got_walk.heading !== want_walk.heading) begin
            $error("heading expected %0d got %0d", want_walk.heading, got_walk.heading);
            failures++;
          end
          if (got_walk.revisited !== want_walk.revisited) begin
            $error("revisited expected %0d got %0d", want_walk.revisited,
                   got_walk.revisited);
            failures++;
          end
          if (got_walk.finished !== want_walk.finished) begin
            $error("finished expected %0d got %0d", want_walk.finished, got_walk.finished);
            failures++;
          end
          if (got_walk.stuck !== want_walk.stuck) begin
            $error("stuck expected %0d got %0d", want_walk.stuck, got_walk.stuck);
            failures++;
          end
          if (want_walk.finished) finished_seen++;
          if (want_walk.stuck) stuck_seen++;
          if (want_walk.revisited) revisit_seen++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        items_accepted++;
        if (predict_walk('{kind: kind_i, row: row_i, column: column_i, wall: wall_i}, new_walk))
          expected_walk.push_back(new_walk);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int pick;
    wall_bits = '0;
    visited_bits = '0;
    at_row = '0;
    at_col = '0;
    heading_now = rhw_pkg::DIR_EAST;
    has_moved = 1'b0;
    walk_over = 1'b0;

    // From the reset position: one move south, then a finish on the border,
    // then a step after the walk has ended.
    add_item(rhw_pkg::KIND_STEP, 4'd0, 4'd0, 1'b0);
    add_item(rhw_pkg::KIND_STEP, 4'd15, 4'd15, 1'b1);
    add_item(rhw_pkg::KIND_STEP, 4'd0, 4'd0, 1'b0);
    add_item(KIND_UNUSED, 4'd15, 4'd15, 1'b1);
    // A walker boxed in on all four sides.
    add_item(rhw_pkg::KIND_WRITE, 4'd4, 4'd5, 1'b1);
    add_item(rhw_pkg::KIND_WRITE, 4'd6, 4'd5, 1'b1);
    add_item(rhw_pkg::KIND_WRITE, 4'd5, 4'd4, 1'b1);
    add_item(rhw_pkg::KIND_WRITE, 4'd5, 4'd6, 1'b1);
    add_item(rhw_pkg::KIND_START, 4'd5, 4'd5, 1'b0);
    add_item(rhw_pkg::KIND_STEP, 4'd5, 4'd5, 1'b0);
    add_item(rhw_pkg::KIND_STEP, 4'd5, 4'd5, 1'b0);
    // Starting on a wall cell.
    add_item(rhw_pkg::KIND_START, 4'd4, 4'd5, 1'b1);
    add_item(rhw_pkg::KIND_STEP, 4'd0, 4'd0, 1'b0);
    add_item(rhw_pkg::KIND_STEP, 4'd0, 4'd0, 1'b0);
    // The far corner, where only the left and back sides are inside the grid.
    add_item(rhw_pkg::KIND_START, 4'd15, 4'd15, 1'b0);
    add_item(rhw_pkg::KIND_STEP, 4'd15, 4'd15, 1'b1);
    add_item(rhw_pkg::KIND_STEP, 4'd15, 4'd15, 1'b1);
    add_item(rhw_pkg::KIND_WRITE, 4'd15, 4'd15, 1'b1);
    add_item(rhw_pkg::KIND_WRITE, 4'd0, 4'd0, 1'b1);
    add_item(rhw_pkg::KIND_START, 4'd0, 4'd1, 1'b0);
    add_item(rhw_pkg::KIND_STEP, 4'd0, 4'd1, 1'b0);

    while (walk_count < WALK_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(4, 30);
        repeat (n) begin
          add_item(rhw_pkg::KIND_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   $urandom_range(0, 99) < 35);
        end
        add_item(rhw_pkg::KIND_START, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
        n = $urandom_range(2, 40);
        repeat (n) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            add_item(rhw_pkg::KIND_WRITE, 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          end else if (pick == 1) begin
            add_item(KIND_UNUSED, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
          end else begin
            add_item(rhw_pkg::KIND_STEP, 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
          end
        end
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          add_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(items_accepted == items_total && expected_walk.size() == 0) &&
           idle_cycles < STALL_LIMIT) begin
      @(negedge clk_i);
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $error("No transfer for %0d cycles, %0d of %0d items accepted", STALL_LIMIT,
             items_accepted, items_total);
      failures++;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      if (expected_walk.size() != 0) begin
        $error("%0d step results never arrived", expected_walk.size());
        failures++;
      end
    end

    $display("Accepted %0d items and checked %0d step results.", items_accepted,
             results_checked);
    $display("Walks ending on the border: %0d, boxed-in reports: %0d, revisits: %0d.",
             finished_seen, stuck_seen, revisit_seen);
    if (failures == 0) begin
      $display("right_hand_maze_walker test passed");
    end else begin
      $display("right_hand_maze_walker test failed");
    end
    $finish;
  end

endmodule
